### sv/vpfa_pkg.sv
package vpfa_pkg;

    // Frame geometry and header format
    localparam int MAX_SLOTS        = 128;
    localparam int PKT_LINES        = 4;
    localparam int LINE_PIXELS      = 384;
    localparam int PIXEL_BITS       = 4;
    localparam int RATE_SPLIT_LINES = 250;

    localparam int LAST_BIT = 15;
    localparam int LINE_W   = 15;
    localparam int SLOT_W   = 7;
    localparam int CNT_W    = 8;

    // Queue between classifier and frame engine
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // Register reset values
    localparam logic [15:0] TIMEOUT_RST = 16'd100;
    localparam logic [14:0] PAL_RST     = 15'd272;
    localparam logic [14:0] NTSC_RST    = 15'd240;

    // Register indexes
    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_PAL     = 2'd1;
    localparam logic [1:0] CFG_NTSC    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_STORED       = 2'd0;
    localparam logic [1:0] ST_DUPLICATE    = 2'd1;
    localparam logic [1:0] ST_BAD_FORMAT   = 2'd2;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

    // Format codes
    localparam logic [1:0] FMT_NONE    = 2'd0;
    localparam logic [1:0] FMT_PAL     = 2'd1;
    localparam logic [1:0] FMT_NTSC    = 2'd2;
    localparam logic [1:0] FMT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [14:0] pal_height;
        logic [14:0] ntsc_height;
    } cfg_t;

    // Classified header, one queue entry
    typedef struct packed {
        logic              seq_gap;
        logic              fmt_ok;
        logic              slot_oob;
        logic              last;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       frame_id;
        logic [15:0]       height;
        logic              low_height;
        logic [31:0]       now;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
        logic              seq_gap;
        logic              old_frame_timed_out;
        logic              frame_done;
        logic [15:0]       done_frame_id;
        logic [1:0]        format_code;
        logic [15:0]       detected_height;
        logic              sixty_hz;
    } result_t;

endpackage

### sv/vpfa_front.sv
module vpfa_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           hdr_accept,
    input  logic [15:0]    seq_num,
    input  logic [15:0]    frame_id,
    input  logic [15:0]    line_field,
    input  logic [15:0]    line_width,
    input  logic [7:0]     lines_in_packet,
    input  logic [7:0]     pixel_depth,
    input  logic [31:0]    arrival_ms,
    output vpfa_pkg::cmd_t cmd
);
    import vpfa_pkg::*;

    logic [15:0]       last_seq_reg;
    logic [15:0]       last_seq_next;
    logic              seen_reg;
    logic              seen_next;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] slot_full;
    logic [15:0]       height;
    logic              fmt_ok;

    always_comb
    begin
        line      = line_field[LINE_W-1:0];
        slot_full = LINE_W'(line / PKT_LINES);
        height    = 16'(line) + 16'(PKT_LINES);
        fmt_ok    = (lines_in_packet == 8'(PKT_LINES)) &&
                    (line_width == 16'(LINE_PIXELS)) &&
                    (pixel_depth == 8'(PIXEL_BITS));

        cmd.seq_gap    = seen_reg && (seq_num != (last_seq_reg + 16'd1));
        cmd.fmt_ok     = fmt_ok;
        cmd.slot_oob   = slot_full >= LINE_W'(MAX_SLOTS);
        cmd.last       = line_field[LAST_BIT];
        cmd.slot       = fmt_ok ? slot_full[SLOT_W-1:0] : '0;
        cmd.frame_id   = frame_id;
        cmd.height     = height;
        cmd.low_height = height <= 16'(RATE_SPLIT_LINES);
        cmd.now        = arrival_ms;

        last_seq_next = hdr_accept ? seq_num : last_seq_reg;
        seen_next     = seen_reg | hdr_accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg <= '0;
            seen_reg     <= 1'b0;
        end
        else
        begin
            last_seq_reg <= last_seq_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

### sv/vpfa_queue.sv
module vpfa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vpfa_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output vpfa_pkg::cmd_t pop_data
);
    import vpfa_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg;
    logic [Q_PTR_W:0]   count_next;

    always_comb
    begin
        full     = count_reg == (Q_PTR_W+1)'(Q_DEPTH);
        empty    = count_reg == '0;
        pop_data = mem_reg[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        priority if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/vpfa_back.sv
module vpfa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  vpfa_pkg::cfg_t    cfg,
    input  logic              q_empty,
    input  vpfa_pkg::cmd_t    cmd,
    output logic              q_pop,
    input  logic              res_stall,
    output logic              res_valid,
    output vpfa_pkg::result_t res
);
    import vpfa_pkg::*;

    // Frame state
    logic [MAX_SLOTS-1:0] slots_reg, slots_next, slots_b;
    logic [CNT_W-1:0]     rcnt_reg, rcnt_next, rcnt_b;
    logic [CNT_W-1:0]     ecnt_reg, ecnt_next, ecnt_b;
    logic [15:0]          cur_id_reg, cur_id_next, cur_id_b;
    logic [31:0]          fstart_reg, fstart_next, fstart_b;
    logic [15:0]          lci_reg, lci_next;
    logic                 fv_reg, fv_next;
    logic [15:0]          hs_reg, hs_next;
    logic                 rate_reg, rate_next;

    logic                 res_valid_reg;
    result_t              res_reg;
    result_t              res_next;

    logic                 chg;
    logic [31:0]          elapsed;

    assign q_pop     = !q_empty && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        // A new frame number drops the frame in progress
        chg      = cmd.fmt_ok && (cur_id_reg != cmd.frame_id);
        elapsed  = cmd.now - fstart_reg;
        slots_b  = chg ? '0 : slots_reg;
        rcnt_b   = chg ? '0 : rcnt_reg;
        ecnt_b   = chg ? '0 : ecnt_reg;
        cur_id_b = chg ? cmd.frame_id : cur_id_reg;
        fstart_b = chg ? cmd.now : fstart_reg;

        slots_next  = slots_b;
        rcnt_next   = rcnt_b;
        ecnt_next   = ecnt_b;
        cur_id_next = cur_id_b;
        fstart_next = fstart_b;
        lci_next    = lci_reg;
        fv_next     = fv_reg;
        hs_next     = hs_reg;
        rate_next   = rate_reg;

        res_next.status              = ST_STORED;
        res_next.slot_index          = cmd.slot;
        res_next.seq_gap             = cmd.seq_gap;
        res_next.old_frame_timed_out = chg && (rcnt_reg != '0) &&
                                       (elapsed > {16'd0, cfg.timeout_ms});
        res_next.frame_done          = 1'b0;
        res_next.done_frame_id       = '0;

        priority if (!cmd.fmt_ok)
            res_next.status = ST_BAD_FORMAT;
        else if (cmd.slot_oob)
            res_next.status = ST_OUT_OF_RANGE;
        else
        begin
            if (slots_b[cmd.slot])
                res_next.status = ST_DUPLICATE;
            else
            begin
                slots_next[cmd.slot] = 1'b1;
                rcnt_next            = rcnt_b + 1'b1;
            end

            // Last packet fixes the slot count and the height
            if (cmd.last && (ecnt_b == '0))
            begin
                ecnt_next = CNT_W'(cmd.slot) + 1'b1;
                if (!fv_reg || (hs_reg != cmd.height))
                begin
                    hs_next = cmd.height;
                    fv_next = 1'b1;
                    priority if (cmd.height == {1'b0, cfg.pal_height})
                        rate_next = 1'b0;
                    else if (cmd.height == {1'b0, cfg.ntsc_height})
                        rate_next = 1'b1;
                    else
                        rate_next = cmd.low_height;
                end
            end

            // Completion: report a frame number only if it differs from the last one reported, restart on frame 0
            if ((rcnt_next != '0) && (rcnt_next == ecnt_next))
            begin
                if (lci_reg != cur_id_b)
                begin
                    res_next.frame_done    = 1'b1;
                    res_next.done_frame_id = cur_id_b;
                    lci_next               = cur_id_b;
                end
                slots_next  = '0;
                rcnt_next   = '0;
                ecnt_next   = '0;
                cur_id_next = '0;
                fstart_next = cmd.now;
            end
        end

        priority if (!fv_next)
            res_next.format_code = FMT_NONE;
        else if (hs_next == {1'b0, cfg.pal_height})
            res_next.format_code = FMT_PAL;
        else if (hs_next == {1'b0, cfg.ntsc_height})
            res_next.format_code = FMT_NTSC;
        else
            res_next.format_code = FMT_UNKNOWN;

        res_next.detected_height = hs_next;
        res_next.sixty_hz        = rate_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= '0;
            rcnt_reg      <= '0;
            ecnt_reg      <= '0;
            cur_id_reg    <= '0;
            fstart_reg    <= '0;
            lci_reg       <= '0;
            fv_reg        <= 1'b0;
            hs_reg        <= '0;
            rate_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                slots_reg  <= slots_next;
                rcnt_reg   <= rcnt_next;
                ecnt_reg   <= ecnt_next;
                cur_id_reg <= cur_id_next;
                fstart_reg <= fstart_next;
                lci_reg    <= lci_next;
                fv_reg     <= fv_next;
                hs_reg     <= hs_next;
                rate_reg   <= rate_next;
            end
            if (q_pop)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            res_reg <= res_next;
    end

endmodule

### sv/video_packet_frame_assembler_unit.sv
// A header accepted at one edge is written into the queue, then popped into the result
// register; the result is held while the result port stalls.
// Throughput: one header per cycle while the result port does not stall.
// A four-entry queue lets the header side run on while the result side stalls.
// Reset (rst_n, async, active low) clears all frame and sequence state and the queue,
// and loads the register reset values.
module video_packet_frame_assembler_unit (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // Header channel
    input  logic        hdr_valid,
    output logic        hdr_stall,
    input  logic [15:0] seq_num,
    input  logic [15:0] frame_id,
    input  logic [15:0] line_field,
    input  logic [15:0] line_width,
    input  logic [7:0]  lines_in_packet,
    input  logic [7:0]  pixel_depth,
    input  logic [31:0] arrival_ms,

    // Result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic [6:0]  slot_index,
    output logic        seq_gap,
    output logic        old_frame_timed_out,
    output logic        frame_done,
    output logic [15:0] done_frame_id,
    output logic [1:0]  format_code,
    output logic [15:0] detected_height,
    output logic        sixty_hz
);
    import vpfa_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    cmd_t    front_cmd;
    cmd_t    queue_cmd;
    result_t res;
    logic    hdr_accept;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;

    // The user must write registers only while the pipe is empty; the block does not enforce it
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: cfg_next.timeout_ms  = cfg_data;
                CFG_PAL:     cfg_next.pal_height  = cfg_data[14:0];
                CFG_NTSC:    cfg_next.ntsc_height = cfg_data[14:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms  <= TIMEOUT_RST;
            cfg_reg.pal_height  <= PAL_RST;
            cfg_reg.ntsc_height <= NTSC_RST;
        end
        else
            cfg_reg <= cfg_next;
    end

    // Front: sequence tracking and header classification
    assign hdr_stall  = q_full;
    assign hdr_accept = hdr_valid && !hdr_stall;

    vpfa_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .hdr_accept      (hdr_accept),
        .seq_num         (seq_num),
        .frame_id        (frame_id),
        .line_field      (line_field),
        .line_width      (line_width),
        .lines_in_packet (lines_in_packet),
        .pixel_depth     (pixel_depth),
        .arrival_ms      (arrival_ms),
        .cmd             (front_cmd)
    );

    vpfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (hdr_accept),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (queue_cmd)
    );

    // Back: frame bitmap, completion, format detect, result register
    vpfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .cmd       (queue_cmd),
        .q_pop     (q_pop),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res)
    );

    assign status              = res.status;
    assign slot_index          = res.slot_index;
    assign seq_gap             = res.seq_gap;
    assign old_frame_timed_out = res.old_frame_timed_out;
    assign frame_done          = res.frame_done;
    assign done_frame_id       = res.done_frame_id;
    assign format_code         = res.format_code;
    assign detected_height     = res.detected_height;
    assign sixty_hz            = res.sixty_hz;

    // Completion only happens on a stored or duplicate packet
    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_done |-> status == ST_STORED || status == ST_DUPLICATE)
        else $error("frame_done on a rejected packet");

    a_done_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !frame_done |-> done_frame_id == 16'd0)
        else $error("done_frame_id set without frame_done");

    // Bad format leaves frame state alone, so no timeout drop
    a_tout_format: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && old_frame_timed_out |-> status != ST_BAD_FORMAT)
        else $error("timeout reported on bad-format packet");

    // Results pop only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

### tb/tb_video_packet_frame_assembler_unit.sv
`timescale 1ns / 1ps

module tb_video_packet_frame_assembler_unit;
    import vpfa_pkg::*;

    // Run limits
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;    // long result-side hold-off, fills the header queue
    localparam int PHASE_ITEMS  = 215;    // random headers per register setting
    localparam int NUM_PHASES   = 6;
    localparam int SETTLE_WAIT  = 4;      // cycles after the last result before a register write

    // One packet header as it is put on the header channel
    typedef struct packed {
        logic [15:0] seq_num;
        logic [15:0] frame_id;
        logic [15:0] line_field;
        logic [15:0] line_width;
        logic [7:0]  lines_in_packet;
        logic [7:0]  pixel_depth;
        logic [31:0] arrival_ms;
    } hdr_t;

    // Directed row: header plus a hand-written outcome where one is typed in
    typedef struct packed {
        hdr_t    hdr;
        logic    typed;
        result_t outcome;
    } row_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    // Block ports
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_TIMEOUT;
    logic [15:0] cfg_data  = '0;

    logic        hdr_valid = 1'b0;
    logic        hdr_stall;
    logic [15:0] seq_num;
    logic [15:0] frame_id;
    logic [15:0] line_field;
    logic [15:0] line_width;
    logic [7:0]  lines_in_packet;
    logic [7:0]  pixel_depth;
    logic [31:0] arrival_ms;

    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  status;
    logic [6:0]  slot_index;
    logic        seq_gap;
    logic        old_frame_timed_out;
    logic        frame_done;
    logic [15:0] done_frame_id;
    logic [1:0]  format_code;
    logic [15:0] detected_height;
    logic        sixty_hz;

    // Header payload is driven as one struct; the typed outcome rides along with it
    hdr_t    hdr_drv       = '0;
    logic    hdr_typed     = 1'b0;
    result_t hdr_typed_res = '0;

    assign seq_num         = hdr_drv.seq_num;
    assign frame_id        = hdr_drv.frame_id;
    assign line_field      = hdr_drv.line_field;
    assign line_width      = hdr_drv.line_width;
    assign lines_in_packet = hdr_drv.lines_in_packet;
    assign pixel_depth     = hdr_drv.pixel_depth;
    assign arrival_ms      = hdr_drv.arrival_ms;

    video_packet_frame_assembler_unit i_dut (.*);

    // ------------------------------------------------------------------
    // Assembler prediction: own copy of registers and frame state.
    // Reset is applied once, so the declaration values are the reset state.
    // ------------------------------------------------------------------
    cfg_t        regs = '{TIMEOUT_RST, PAL_RST, NTSC_RST};

    logic [15:0] prev_seq      = '0;
    logic        have_seq      = 1'b0;
    logic [15:0] cur_frame     = '0;
    logic        slot_seen [MAX_SLOTS];
    int          got_cnt       = 0;
    int          want_cnt      = 0;
    logic [31:0] frame_t0      = '0;
    logic [15:0] last_done_id  = '0;
    logic        fmt_locked    = 1'b0;
    logic [15:0] locked_height = '0;
    logic        sixty         = 1'b0;

    initial
    begin
        foreach (slot_seen[i]) slot_seen[i] = 1'b0;
    end

    // Outcomes predicted for accepted headers, oldest first
    result_t header_outcomes [$];
    int      mismatch_count = 0;

    // Stimulus-side state
    int          snd_idle    = 0;     // percent of cycles the header side holds back
    int          rcv_idle    = 0;     // percent of cycles the result side stalls
    logic        pressure_on = 1'b0;
    int          hold_cnt    = 0;
    int          items_sent  = 0;
    int          cycle_cnt   = 0;
    logic [15:0] seq_ctr     = '0;
    logic [15:0] gen_fid     = '0;
    logic [31:0] now_ms      = '0;
    row_t        directed_rows [$];

    task automatic open_frame(input logic [15:0] id, input logic [31:0] now);
        foreach (slot_seen[i]) slot_seen[i] = 1'b0;
        got_cnt   = 0;
        want_cnt  = 0;
        cur_frame = id;
        frame_t0  = now;
    endtask

    // Works out the result of one header and advances the frame state
    task automatic assemble_header(input hdr_t h, output result_t r);
        logic last_pkt;
        int   line;
        int   slot;
        int   hgt;
        r        = '0;
        last_pkt = h.line_field[LAST_BIT];
        line     = h.line_field[LINE_W-1:0];

        if (have_seq && h.seq_num != 16'(prev_seq + 16'd1))
            r.seq_gap = 1'b1;
        prev_seq = h.seq_num;
        have_seq = 1'b1;

        if (h.lines_in_packet != PKT_LINES || h.line_width != LINE_PIXELS ||
            h.pixel_depth != PIXEL_BITS)
        begin
            // bad format: only the sequence tracking moves
            r.status = ST_BAD_FORMAT;
        end
        else
        begin
            if (cur_frame != h.frame_id)
            begin
                if (got_cnt > 0 && 32'(h.arrival_ms - frame_t0) > {16'd0, regs.timeout_ms})
                    r.old_frame_timed_out = 1'b1;
                open_frame(h.frame_id, h.arrival_ms);
            end
            slot         = line / PKT_LINES;
            r.slot_index = slot[SLOT_W-1:0];
            if (slot >= MAX_SLOTS)
            begin
                r.status = ST_OUT_OF_RANGE;
            end
            else
            begin
                if (slot_seen[slot])
                begin
                    r.status = ST_DUPLICATE;
                end
                else
                begin
                    slot_seen[slot] = 1'b1;
                    got_cnt++;
                    r.status = ST_STORED;
                end
                // first last-packet of a frame fixes its size and the video format
                if (last_pkt && want_cnt == 0)
                begin
                    hgt      = line + h.lines_in_packet;
                    want_cnt = slot + 1;
                    if (!fmt_locked || locked_height != hgt)
                    begin
                        locked_height = 16'(hgt);
                        fmt_locked    = 1'b1;
                        if (hgt == regs.pal_height)
                            sixty = 1'b0;
                        else if (hgt == regs.ntsc_height)
                            sixty = 1'b1;
                        else
                            sixty = (hgt <= RATE_SPLIT_LINES);
                    end
                end
                if (got_cnt > 0 && got_cnt == want_cnt)
                begin
                    // a frame number is not reported twice in a row; assembly restarts on frame 0 anyway
                    if (last_done_id != cur_frame)
                    begin
                        r.frame_done    = 1'b1;
                        r.done_frame_id = cur_frame;
                        last_done_id    = cur_frame;
                    end
                    open_frame(16'd0, h.arrival_ms);
                end
            end
        end

        if (!fmt_locked)
            r.format_code = FMT_NONE;
        else if (locked_height == {1'b0, regs.pal_height})
            r.format_code = FMT_PAL;
        else if (locked_height == {1'b0, regs.ntsc_height})
            r.format_code = FMT_NTSC;
        else
            r.format_code = FMT_UNKNOWN;
        r.detected_height = locked_height;
        r.sixty_hz        = sixty;
    endtask

    task automatic compare_outcome(input result_t want, input result_t got);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.slot_index !== want.slot_index)
        begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
            mismatch_count++;
        end
        if (got.seq_gap !== want.seq_gap)
        begin
            $error("seq_gap: expected %0d, got %0d", want.seq_gap, got.seq_gap);
            mismatch_count++;
        end
        if (got.old_frame_timed_out !== want.old_frame_timed_out)
        begin
            $error("old_frame_timed_out: expected %0d, got %0d",
                   want.old_frame_timed_out, got.old_frame_timed_out);
            mismatch_count++;
        end
        if (got.frame_done !== want.frame_done)
        begin
            $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
            mismatch_count++;
        end
        if (got.done_frame_id !== want.done_frame_id)
        begin
            $error("done_frame_id: expected %0d, got %0d",
                   want.done_frame_id, got.done_frame_id);
            mismatch_count++;
        end
        if (got.format_code !== want.format_code)
        begin
            $error("format_code: expected %0d, got %0d", want.format_code, got.format_code);
            mismatch_count++;
        end
        if (got.detected_height !== want.detected_height)
        begin
            $error("detected_height: expected %0d, got %0d",
                   want.detected_height, got.detected_height);
            mismatch_count++;
        end
        if (got.sixty_hz !== want.sixty_hz)
        begin
            $error("sixty_hz: expected %0d, got %0d", want.sixty_hz, got.sixty_hz);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: both channels sampled at the edge that accepts an item.
    // A result accepted at an edge belongs to a header accepted earlier, so
    // pushing before popping keeps the order right.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        result_t predicted;
        result_t observed;
        if (rst_n)
        begin
            if (hdr_valid && !hdr_stall)
            begin
                assemble_header(hdr_drv, predicted);
                header_outcomes.push_back(hdr_typed ? hdr_typed_res : predicted);
            end
            if (res_valid && !res_stall)
            begin
                observed = '{status, slot_index, seq_gap, old_frame_timed_out, frame_done,
                             done_frame_id, format_code, detected_height, sixty_hz};
                if (header_outcomes.size() == 0)
                begin
                    $error("result item with no header outstanding");
                    mismatch_count++;
                end
                else
                begin
                    compare_outcome(header_outcomes.pop_front(), observed);
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold-off so the header side backs up
    always @(posedge clk)
    begin
        if (pressure_on && hold_cnt < HOLD_CYCLES)
        begin
            res_stall <= 1'b1;
            hold_cnt  <= hold_cnt + 1;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic hdr_t mk_hdr(input logic [15:0] seq, input logic [15:0] fid,
                                    input logic [15:0] lf, input logic [31:0] now);
        return '{seq, fid, lf, 16'(LINE_PIXELS), 8'(PKT_LINES), 8'(PIXEL_BITS), now};
    endfunction

    // Outcome with no frame progress and no format detected yet
    function automatic result_t quiet(input logic [1:0] st, input logic [6:0] slot,
                                      input logic gap);
        result_t r;
        r            = '0;
        r.status     = st;
        r.slot_index = slot;
        r.seq_gap    = gap;
        return r;
    endfunction

    // Mostly consecutive sequence numbers, with the odd jump
    function automatic logic [15:0] next_seq();
        if ($urandom_range(99) < 3)
            seq_ctr = 16'($urandom);
        else
            seq_ctr = seq_ctr + 16'd1;
        return seq_ctr;
    endfunction

    // Offer one header, holding it until accepted; valid drops only while the header side holds back
    task automatic send_header(input hdr_t h, input logic typed, input result_t r);
        while ($urandom_range(99) < snd_idle)
        begin
            hdr_valid <= 1'b0;
            @(posedge clk);
        end
        hdr_valid     <= 1'b1;
        hdr_drv       <= h;
        hdr_typed     <= typed;
        hdr_typed_res <= r;
        @(posedge clk);
        while (hdr_stall) @(posedge clk);
        items_sent++;
    endtask

    // Malformed header, or a well-formed one with a random frame number and line
    task automatic send_noise();
        hdr_t h;
        h = mk_hdr(next_seq(), gen_fid, 16'($urandom), now_ms);
        case ($urandom_range(3))
            0:       h.line_width      = 16'($urandom);
            1:       h.lines_in_packet = 8'($urandom);
            2:       h.pixel_depth     = 8'($urandom);
            default: h.frame_id        = 16'($urandom);
        endcase
        send_header(h, 1'b0, '0);
    endtask

    // One frame: all slots in random order, the top slot carrying the last flag,
    // with occasional lost packets, duplicates and noise in between
    task automatic play_frame();
        hdr_t        h;
        int          pick;
        int          tgt;
        int          last_line;
        int          n;
        int          order [$];
        logic [15:0] lf;

        pick = $urandom_range(99);
        if (pick < 60)
            gen_fid = gen_fid + 16'($urandom_range(1, 3));
        else if (pick < 75)
            gen_fid = '0;
        else if (pick >= 85)
            gen_fid = 16'($urandom);
        // 75..84: same frame number again

        // frame height; PAL and NTSC targets only fit when small enough
        pick = $urandom_range(99);
        if (pick < 20)
            tgt = regs.pal_height;
        else if (pick < 40)
            tgt = regs.ntsc_height;
        else if (pick < 45)
            tgt = $urandom_range(PKT_LINES, PKT_LINES * (MAX_SLOTS + 1) - 1);
        else
            tgt = PKT_LINES * $urandom_range(1, 6) + $urandom_range(0, 3);
        if (tgt < PKT_LINES || tgt > PKT_LINES * (MAX_SLOTS + 1) - 1)
            tgt = PKT_LINES * $urandom_range(1, 6) + $urandom_range(0, 3);
        last_line = tgt - PKT_LINES;
        n         = last_line / PKT_LINES + 1;

        // gap since the previous frame: short, around the timeout, or anything
        pick = $urandom_range(99);
        if (pick < 15)
            now_ms = now_ms + $urandom_range(0, 2 * regs.timeout_ms + 2);
        else if (pick < 18)
            now_ms = now_ms + $urandom;
        else
            now_ms = now_ms + $urandom_range(0, 3);

        for (int s = 0; s < n; s++) order.push_back(s);
        order.shuffle();
        foreach (order[k])
        begin
            if ($urandom_range(99) < 5)
                send_noise();
            if ($urandom_range(99) < 4)
                continue;
            if (order[k] == n - 1)
            begin
                lf           = 16'(last_line);
                lf[LAST_BIT] = 1'b1;
            end
            else
            begin
                lf = 16'(PKT_LINES * order[k] + $urandom_range(0, 3));
            end
            now_ms = now_ms + $urandom_range(0, 2);
            h      = mk_hdr(next_seq(), gen_fid, lf, now_ms);
            send_header(h, 1'b0, '0);
            if ($urandom_range(99) < 4)
            begin
                h.seq_num = next_seq();
                send_header(h, 1'b0, '0);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_TIMEOUT: regs.timeout_ms  = data;
            CFG_PAL:     regs.pal_height  = data[LINE_W-1:0];
            CFG_NTSC:    regs.ntsc_height = data[LINE_W-1:0];
            default:     ;
        endcase
    endtask

    // Drain: every result in, then a few quiet cycles; the first edge lets the
    // scoreboard log the header accepted at the current edge
    task automatic settle();
        hdr_valid <= 1'b0;
        @(posedge clk);
        while (header_outcomes.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        hdr_t        h;
        result_t     r;
        logic [15:0] phase_cfg [NUM_PHASES][3];

        // timeout, PAL height, NTSC height per phase; the last row is redrawn at random
        phase_cfg = '{'{16'd0,     16'hFFFF, 16'd0},     // all-ones write, bit 15 dropped
                      '{16'hFFFF,  16'd0,    16'h7FFF},
                      '{16'd20,    16'd16,   16'd12},    // small frames hit both formats
                      '{16'd5,     16'd24,   16'd252},   // NTSC above the 250-line split
                      '{16'd100,   16'd272,  16'd240},
                      '{16'd0,     16'd0,    16'd0}};

        // Directed rows. Typed outcomes hold while no format has been detected.
        h = mk_hdr(16'd0, 16'd0, 16'h0000, 32'd0);          // first header: no gap
        directed_rows.push_back('{h, 1'b1, quiet(ST_STORED, 7'd0, 1'b0)});
        h = mk_hdr(16'd1, 16'd0, 16'h0000, 32'd1);
        h.lines_in_packet = 8'd0;                            // wrong line count
        directed_rows.push_back('{h, 1'b1, quiet(ST_BAD_FORMAT, 7'd0, 1'b0)});
        h = mk_hdr(16'd5, 16'd0, 16'h0000, 32'd2);
        h.line_width = 16'hFFFF;                             // wrong width, plus a gap
        directed_rows.push_back('{h, 1'b1, quiet(ST_BAD_FORMAT, 7'd0, 1'b1)});
        h = mk_hdr(16'd6, 16'd0, 16'h0000, 32'd3);
        h.lines_in_packet = 8'hFF;
        h.pixel_depth     = 8'hFF;
        directed_rows.push_back('{h, 1'b1, quiet(ST_BAD_FORMAT, 7'd0, 1'b0)});
        h = mk_hdr(16'd7, 16'd0, 16'h0000, 32'd4);          // slot 0 again
        directed_rows.push_back('{h, 1'b1, quiet(ST_DUPLICATE, 7'd0, 1'b0)});
        h = mk_hdr(16'd8, 16'd0, 16'h7FFF, 32'd5);          // top line, slot out of range
        directed_rows.push_back('{h, 1'b1, quiet(ST_OUT_OF_RANGE, 7'd127, 1'b0)});
        h = mk_hdr(16'd9, 16'd0, 16'hFFFF, 32'd6);          // same, last flag ignored
        directed_rows.push_back('{h, 1'b1, quiet(ST_OUT_OF_RANGE, 7'd127, 1'b0)});
        // last packet in slot 1: height 8, 60 Hz; frame 0 completes but is not reported
        h = mk_hdr(16'd10, 16'd0, 16'h8004, 32'd10);
        r = '{ST_STORED, 7'd1, 1'b0, 1'b0, 1'b0, 16'd0, FMT_UNKNOWN, 16'd8, 1'b1};
        directed_rows.push_back('{h, 1'b1, r});

        // Rows below go through the predictor
        h = mk_hdr(16'd11, 16'd5, 16'h810C, 32'd20);        // new frame, PAL height
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'd12, 16'd5, 16'h0001, 32'd30);
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'd13, 16'd6, 16'h0002, 32'd200);       // frame 5 dropped on timeout
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'd14, 16'd7, 16'h8000, 32'd201);       // silent drop, one-slot frame done
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'd15, 16'd7, 16'h8003, 32'd202);       // same number completes again
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'd16, 16'hFFFF, 16'h80EC, 32'd300);    // NTSC height, top frame number
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'hFFFF, 16'h1234, 16'h80F8, 32'hFFFF_FFF0); // height 252: 50 Hz
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'h0000, 16'h1234, 16'h00F4, 32'h0000_0010);  // sequence wraps
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'd1, 16'h4321, 16'h80F4, 32'h0000_0020);     // time wraps, no timeout
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'd2, 16'h4321, 16'h8008, 32'h0000_0021);     // second last flag ignored
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'd3, 16'h5555, 16'h0000, 32'h0000_0084);     // elapsed equals timeout
        directed_rows.push_back('{h, 1'b0, result_t'('0)});
        h = mk_hdr(16'd4, 16'h5556, 16'h0000, 32'h0000_00E9);     // elapsed one past timeout
        directed_rows.push_back('{h, 1'b0, result_t'('0)});

        // Reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle = 35;
        rcv_idle = 55;
        foreach (directed_rows[i])
            send_header(directed_rows[i].hdr, directed_rows[i].typed, directed_rows[i].outcome);

        seq_ctr = 16'($urandom);
        now_ms  = $urandom;
        gen_fid = 16'($urandom);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            if (ph == NUM_PHASES - 1)
            begin
                phase_cfg[ph][0] = 16'($urandom_range(0, 300));
                phase_cfg[ph][1] = 16'(PKT_LINES * $urandom_range(1, 30));
                phase_cfg[ph][2] = 16'(PKT_LINES * $urandom_range(1, 30));
            end
            write_reg(CFG_TIMEOUT, phase_cfg[ph][0]);
            write_reg(CFG_PAL,     phase_cfg[ph][1]);
            write_reg(CFG_NTSC,    phase_cfg[ph][2]);
            cfg_wr_en <= 1'b0;

            // result side idles more first, then the header side, then neither
            case (ph / 2)
                0:       begin snd_idle = 35; rcv_idle = 55; end
                1:       begin snd_idle = 55; rcv_idle = 35; end
                default: begin snd_idle = 0;  rcv_idle = 0;  end
            endcase
            if (ph == 1)
                pressure_on = 1'b1;

            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                play_frame();
        end

        settle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
